[sv/rpn_pkg.sv]
package rpn_pkg;

  // Operand and result width
  localparam int DATA_W = 32;

  // Default operand stack depth
  localparam int STACK_DEPTH_DEF = 64;

  // Token codes (ASCII)
  localparam logic [7:0] TOK_PLUS  = 8'h2B;
  localparam logic [7:0] TOK_MINUS = 8'h2D;
  localparam logic [7:0] TOK_MUL   = 8'h2A;
  localparam logic [7:0] TOK_DIV   = 8'h2F;
  localparam logic [7:0] TOK_ZERO  = 8'h30;
  localparam logic [7:0] TOK_NINE  = 8'h39;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_in;    // capture accepted token
    logic       rd_issue;   // read second-from-top operand
    logic       alu_load;   // register add/sub/mul result
    logic       div_start;  // launch divider
    logic       commit;     // update stack and load result register
    logic       push;       // commit pushes a digit
    logic       pop;        // commit replaces two operands by one
    logic [2:0] status;     // status code for this token
  } rpn_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;      // stack holds its maximum
    logic lt2;       // fewer than two operands
    logic b_zero;    // top operand is zero
    logic div_busy;
    logic out_free;  // result register can take a new result
  } rpn_stat_t;

endpackage

[sv/rpn_div.sv]
module rpn_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rpn_pkg::DATA_W-1:0]     a,
  input  logic [rpn_pkg::DATA_W-1:0]     b,
  output logic                           busy,
  output logic [rpn_pkg::DATA_W-1:0]     q
);

  localparam int W  = rpn_pkg::DATA_W;
  localparam int CW = $clog2(W);

  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  mb;
  logic          neg;

  logic [W:0]    rem_sh;
  logic [W:0]    trial;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem, quo[W-1]};
  assign trial  = rem_sh - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Magnitudes on start, then shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      mb  <= b[W-1] ? (~b + 1'b1) : b;
      quo <= a[W-1] ? (~a + 1'b1) : a;
      rem <= '0;
      neg <= a[W-1] ^ b[W-1];
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  // Sign fix-up, truncation toward zero
  assign q = neg ? (~quo + 1'b1) : quo;

endmodule

[sv/rpn_datapath.sv]
module rpn_datapath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpn_pkg::rpn_cmd_t             cmd,
  output rpn_pkg::rpn_stat_t            stat,
  input  logic [7:0]                    token,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rpn_pkg::DATA_W-1:0]    top_value,
  output logic [DW-1:0]                 depth,
  output logic [2:0]                    status,
  output logic                          last_out
);

  localparam int W  = rpn_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    tok;
  logic          last_q;
  logic [DW-1:0] sp;
  logic [W-1:0]  top;
  logic [W-1:0]  rd_data;
  logic [W-1:0]  res;
  logic [W-1:0]  div_q;
  logic          div_busy;

  // Entries below the top; the top itself lives in a register
  logic [W-1:0]  mem [STACK_DEPTH];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] sp_m1;
  logic [DW-1:0] sp_m2;
  logic [DW-1:0] sp_new;
  logic [W-1:0]  top_new;

  assign sp_m1   = sp - DW'(1);
  assign sp_m2   = sp - DW'(2);
  assign wr_addr = sp_m1[AW-1:0];
  assign rd_addr = sp_m2[AW-1:0];

  // Token capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tok    <= token;
      last_q <= last;
    end
  end

  // Decode and stack status
  assign stat.is_digit = (tok >= rpn_pkg::TOK_ZERO) && (tok <= rpn_pkg::TOK_NINE);
  assign stat.is_op    = (tok == rpn_pkg::TOK_PLUS) || (tok == rpn_pkg::TOK_MINUS) ||
                         (tok == rpn_pkg::TOK_MUL)  || (tok == rpn_pkg::TOK_DIV);
  assign stat.is_div   = (tok == rpn_pkg::TOK_DIV);
  assign stat.full     = (sp >= DW'(STACK_DEPTH));
  assign stat.lt2      = (sp < DW'(2));
  assign stat.b_zero   = (top == '0);
  assign stat.div_busy = div_busy;
  assign stat.out_free = !result_valid || !result_stall;

  // Operand memory: push spills the old top, operators read second-from-top
  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.push && (sp != '0)) begin
      mem[wr_addr] <= top;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Add, subtract, multiply (low word)
  always_ff @(posedge clk) begin
    if (cmd.alu_load) begin
      case (tok)
        rpn_pkg::TOK_PLUS:  res <= rd_data + top;
        rpn_pkg::TOK_MINUS: res <= rd_data - top;
        rpn_pkg::TOK_MUL:   res <= rd_data * top;
        default:            res <= '0;
      endcase
    end
  end

  rpn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (rd_data),
    .b     (top),
    .busy  (div_busy),
    .q     (div_q)
  );

  // Stack after this token
  always_comb begin
    sp_new  = sp;
    top_new = top;
    if (cmd.push) begin
      sp_new  = sp + DW'(1);
      top_new = {{(W-8){1'b0}}, tok - rpn_pkg::TOK_ZERO};
    end else if (cmd.pop) begin
      sp_new  = sp_m1;
      top_new = stat.is_div ? div_q : res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.commit) begin
      sp <= last_q ? '0 : sp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top <= top_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_value <= (sp_new != '0) ? top_new : '0;
      depth     <= sp_new;
      status    <= cmd.status;
      last_out  <= last_q;
    end
  end

endmodule

[sv/rpn_ctrl.sv]
module rpn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                token_valid,
  output logic                token_stall,
  input  rpn_pkg::rpn_stat_t  stat,
  output rpn_pkg::rpn_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] status_q;
  logic [2:0] status_next;
  logic       push_q;
  logic       push_next;
  logic       pop_q;
  logic       pop_next;

  assign token_stall = (state != S_IDLE);

  // Sequencer
  always_comb begin
    state_next    = state;
    status_next   = status_q;
    push_next     = push_q;
    pop_next      = pop_q;
    cmd           = '0;
    cmd.status    = status_q;
    cmd.push      = push_q;
    cmd.pop       = pop_q;
    case (state)
      S_IDLE: begin
        if (token_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        push_next   = 1'b0;
        pop_next    = 1'b0;
        state_next  = S_FIN;
        if (stat.is_digit) begin
          status_next = stat.full ? rpn_pkg::ST_OVERFLOW : rpn_pkg::ST_OK;
          push_next   = !stat.full;
        end else if (stat.is_op) begin
          status_next = stat.lt2 ? rpn_pkg::ST_UNDERFLOW : rpn_pkg::ST_OK;
          pop_next    = !stat.lt2;
          if (!stat.lt2) begin
            cmd.rd_issue = 1'b1;
            state_next   = S_EXEC;
          end
        end else begin
          status_next = rpn_pkg::ST_INVALID;
        end
      end
      S_EXEC: begin
        cmd.alu_load = 1'b1;
        state_next   = S_FIN;
        if (stat.is_div) begin
          if (stat.b_zero) begin
            status_next = rpn_pkg::ST_DIVZERO;
            pop_next    = 1'b0;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= rpn_pkg::ST_OK;
      push_q   <= 1'b0;
      pop_q    <= 1'b0;
    end else begin
      state    <= state_next;
      status_q <= status_next;
      push_q   <= push_next;
      pop_q    <= pop_next;
    end
  end

endmodule

[sv/postfix_expression_evaluator_top.sv]
// Postfix (RPN) evaluator taking one byte per transfer. Digits push 0..9,
// '+', '-', '*' and '/' combine second-from-top with top in 32-bit wrapping
// arithmetic ('/' truncates toward zero); every byte returns one result with
// the new top, depth and status, and a byte marked last clears the stack
// after its result. A digit, an invalid byte or an underflow passes through
// decode and finish; '+', '-', '*' and a division by zero add an execute
// step, and '/' then waits while the bit-per-cycle divider is busy, until
// the sequencer sees it finish. The next token is taken the cycle after its
// predecessor's result is loaded; a result held by result_stall delays only
// the next commit.
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          token_valid,
  output logic                          token_stall,
  input  logic [7:0]                    token,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [rpn_pkg::DATA_W-1:0] top_value,
  output logic [DW-1:0]                 depth,
  output logic [2:0]                    status,
  output logic                          last_out
);

  rpn_pkg::rpn_cmd_t  cmd;
  rpn_pkg::rpn_stat_t stat;
  logic [rpn_pkg::DATA_W-1:0] top_raw;

  rpn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .token        (token),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .top_value    (top_raw),
    .depth        (depth),
    .status       (status),
    .last_out     (last_out)
  );

  assign top_value = $signed(top_raw);

endmodule
